/* hdl/usmrm_pkg.sv */
// Types and codes shared by the unsorted store min/remove-max blocks.
package usmrm_pkg;

	localparam int VALUE_W  = 32;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef logic [MODE_W-1:0]          mode_t;
	typedef logic [STATUS_W-1:0]        status_t;
	typedef logic [COUNT_W-1:0]         count_t;
	typedef logic signed [VALUE_W-1:0]  value_t;

	localparam mode_t MODE_ADD        = 2'd0;
	localparam mode_t MODE_MIN        = 2'd1;
	localparam mode_t MODE_REMOVE_MAX = 2'd2;

	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_EMPTY = 2'd1;
	localparam status_t STAT_FULL  = 2'd2;

	typedef struct packed {
		mode_t  mode;
		value_t value;
	} req_t;

	typedef struct packed {
		value_t  result_value;
		status_t status;
		count_t  count;
	} rsp_t;

	typedef struct packed {
		logic en;
		logic first;
		logic pick_min;
	} scan_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

/* hdl/usmrm_ram.sv */
// Entry storage: one write port, one registered read port.
module usmrm_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  usmrm_pkg::value_t     wdata,
	input  logic [AW-1:0]         raddr,
	output usmrm_pkg::value_t     rdata
);

	usmrm_pkg::value_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hdl/usmrm_scan.sv */
// Shared comparator with running best value and its slot index.
module usmrm_scan #(
	parameter int AW = 4
) (
	input  logic                   clk,
	input  usmrm_pkg::scan_ctl_t   ctl,
	input  usmrm_pkg::value_t      rdata,
	input  logic [AW-1:0]          idx,
	output usmrm_pkg::value_t      best_nxt,
	output logic [AW-1:0]          at_nxt
);

	usmrm_pkg::value_t best_q;
	logic [AW-1:0]     at_q;
	usmrm_pkg::value_t cmp_a;
	usmrm_pkg::value_t cmp_b;
	logic              take;

	// min: take when rdata < best; max: take when best < rdata
	assign cmp_a = ctl.pick_min ? rdata : best_q;
	assign cmp_b = ctl.pick_min ? best_q : rdata;
	assign take  = ctl.first || (cmp_a < cmp_b);

	assign best_nxt = take ? rdata : best_q;
	assign at_nxt   = take ? idx : at_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			best_q <= best_nxt;
			at_q   <= at_nxt;
		end
	end

endmodule

/* hdl/unsorted_store_min_remove_max_core.sv */
// Unsorted store of signed values with add, report-min and remove-max operations.
// Add, the unused mode code, and min or remove-max on an empty store go from idle
// straight to the done state, which puts their result into the output register.
// Min and remove-max on a non-empty store read the stored entries one per cycle from
// a RAM with one read and one write port, through one shared comparator, in the scan
// state, and then pass through the done state to the output register.
// Remove-max refills the freed slot with the last entry during the final scan cycle.
// The next request is taken once the result has moved into the output register. That
// register frees the request side while the result waits to be taken. While an earlier
// result is still held there, the block stays in its last cycle.
module unsorted_store_min_remove_max_core #(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  usmrm_pkg::req_t     req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output usmrm_pkg::rsp_t     rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	usmrm_pkg::state_t    state_q, state_d;
	usmrm_pkg::mode_t     mode_q;
	logic [CW-1:0]        count_q;
	logic [AW-1:0]        k_q;
	usmrm_pkg::value_t    res_q;
	usmrm_pkg::status_t   stat_q;
	logic                 rsp_valid_q;
	usmrm_pkg::rsp_t      rsp_q;

	logic                 req_fire;
	logic                 rsp_free;
	logic                 full;
	logic                 last;
	logic                 out_load;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	usmrm_pkg::value_t    ram_wdata;
	logic [AW-1:0]        ram_raddr;
	usmrm_pkg::value_t    ram_rdata;
	usmrm_pkg::scan_ctl_t scan_ctl;
	usmrm_pkg::value_t    best_nxt;
	logic [AW-1:0]        at_nxt;

	assign req_fire = req_valid && !req_stall;
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign full     = (count_q == CW'(CAPACITY));
	assign last     = (CW'(k_q) == count_q - CW'(1));

	usmrm_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	usmrm_scan #(
		.AW (AW)
	) u_scan (
		.clk      (clk),
		.ctl      (scan_ctl),
		.rdata    (ram_rdata),
		.idx      (k_q),
		.best_nxt (best_nxt),
		.at_nxt   (at_nxt)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			usmrm_pkg::S_IDLE: begin
				if (req_fire) begin
					if ((req.mode == usmrm_pkg::MODE_MIN ||
					     req.mode == usmrm_pkg::MODE_REMOVE_MAX) && count_q != '0) begin
						state_d = usmrm_pkg::S_SCAN;
					end else begin
						state_d = usmrm_pkg::S_DONE;
					end
				end
			end
			usmrm_pkg::S_SCAN: begin
				if (last) begin
					state_d = usmrm_pkg::S_DONE;
				end
			end
			usmrm_pkg::S_DONE: begin
				if (rsp_free) begin
					state_d = usmrm_pkg::S_IDLE;
				end
			end
			default: state_d = usmrm_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_stall         = (state_q != usmrm_pkg::S_IDLE);
		ram_we            = 1'b0;
		ram_waddr         = count_q[AW-1:0];
		ram_wdata         = req.value;
		ram_raddr         = '0;
		scan_ctl.en       = 1'b0;
		scan_ctl.first    = (k_q == '0);
		scan_ctl.pick_min = (mode_q == usmrm_pkg::MODE_MIN);
		out_load          = 1'b0;
		unique case (state_q)
			usmrm_pkg::S_IDLE: begin
				ram_we = req_fire && (req.mode == usmrm_pkg::MODE_ADD) && !full;
			end
			usmrm_pkg::S_SCAN: begin
				ram_raddr   = k_q + AW'(1);
				scan_ctl.en = 1'b1;
				if (last && mode_q == usmrm_pkg::MODE_REMOVE_MAX) begin
					ram_we    = 1'b1;
					ram_waddr = at_nxt;
					ram_wdata = ram_rdata;
				end
			end
			usmrm_pkg::S_DONE: begin
				out_load = rsp_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= usmrm_pkg::S_IDLE;
			count_q <= '0;
			mode_q  <= usmrm_pkg::MODE_ADD;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == usmrm_pkg::S_IDLE && req_fire) begin
				mode_q <= req.mode;
				k_q    <= '0;
				if (req.mode == usmrm_pkg::MODE_ADD && !full) begin
					count_q <= count_q + CW'(1);
				end
			end else if (state_q == usmrm_pkg::S_SCAN) begin
				k_q <= k_q + AW'(1);
				if (last && mode_q == usmrm_pkg::MODE_REMOVE_MAX) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == usmrm_pkg::S_IDLE && req_fire) begin
			res_q  <= '0;
			stat_q <= usmrm_pkg::STAT_OK;
			unique case (req.mode)
				usmrm_pkg::MODE_ADD: begin
					if (full) begin
						stat_q <= usmrm_pkg::STAT_FULL;
					end
				end
				usmrm_pkg::MODE_MIN, usmrm_pkg::MODE_REMOVE_MAX: begin
					if (count_q == '0) begin
						stat_q <= usmrm_pkg::STAT_EMPTY;
					end
				end
				default: ;
			endcase
		end else if (state_q == usmrm_pkg::S_SCAN && last) begin
			res_q <= best_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q.result_value <= res_q;
			rsp_q.status       <= stat_q;
			rsp_q.count        <= usmrm_pkg::count_t'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
